/* src/lswc_pkg.sv */
// Shared types, constants and codes for the line segment window clipper.
package lswc_pkg;

  localparam int CW     = 16;          // coordinate width, Q3.12
  localparam int DW     = CW + 1;      // width of a coordinate difference
  localparam int U_BITS = 28;          // fraction bits of a segment parameter
  localparam int UW     = U_BITS + 1;  // parameter in [0, 1.0] plus one
  localparam int RW     = UW + 1;      // signed, saturated division result
  localparam int PW     = UW + 1 + DW; // interpolation product
  localparam int CNTW   = $clog2(UW);
  localparam int CS_MAX_MOVES = 4;

  localparam logic [UW-1:0] U_ONE = UW'(1) << U_BITS;

  localparam logic [1:0] KIND_REJECT = 2'd0;
  localparam logic [1:0] KIND_LB     = 2'd1;
  localparam logic [1:0] KIND_CS     = 2'd2;

  localparam logic [3:0] OC_LEFT   = 4'b0001;
  localparam logic [3:0] OC_RIGHT  = 4'b0010;
  localparam logic [3:0] OC_BOTTOM = 4'b0100;
  localparam logic [3:0] OC_TOP    = 4'b1000;

  localparam logic [2:0] REG_XMIN = 3'd0;
  localparam logic [2:0] REG_YMIN = 3'd1;
  localparam logic [2:0] REG_XMAX = 3'd2;
  localparam logic [2:0] REG_YMAX = 3'd3;
  localparam logic [2:0] REG_MODE = 3'd4;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;

  typedef struct packed {
    coord_t xmin;
    coord_t ymin;
    coord_t xmax;
    coord_t ymax;
    logic   mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    coord_t     ax;
    coord_t     ay;
    coord_t     bx;
    coord_t     by;
  } seg_t;

  typedef struct packed {
    logic avail;
    seg_t seg;
  } fq_t;

endpackage

/* src/line_segment_window_clipper.sv */
// Top level of the line segment window clipper: configuration registers, front and back end.
// Clips one segment request against the window in the configuration registers, by
// Liang-Barsky (mode 0) or Cohen-Sutherland (mode 1), and returns one result per
// request. Each division runs on a single iterative divider at one quotient bit a cycle. A
// Liang-Barsky segment needs a division for each edge test (left, right, bottom, top),
// skipped where a direction term is zero, and stops early when an edge test rejects; a
// Cohen-Sutherland segment needs one division per endpoint move, at most four moves, and
// none for a trivial accept or reject. A rejected segment returns visible low and all
// endpoints zero. A two-entry queue in front accepts requests while a segment is clipped, and
// an output register holds a finished result until it is taken. Write the configuration only
// while no request is outstanding.
module line_segment_window_clipper (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  lswc_pkg::coord_t start_x,
  input  lswc_pkg::coord_t start_y,
  input  lswc_pkg::coord_t end_x,
  input  lswc_pkg::coord_t end_y,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             visible,
  output lswc_pkg::coord_t clip_start_x,
  output lswc_pkg::coord_t clip_start_y,
  output lswc_pkg::coord_t clip_end_x,
  output lswc_pkg::coord_t clip_end_y
);
  import lswc_pkg::*;

  cfg_t cfg;
  fq_t  head;
  logic pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.xmin <= -coord_t'(4096);
      cfg.ymin <= -coord_t'(4096);
      cfg.xmax <= coord_t'(4096);
      cfg.ymax <= coord_t'(4096);
      cfg.mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_XMIN: cfg.xmin <= cfg_wdata;
        REG_YMIN: cfg.ymin <= cfg_wdata;
        REG_XMAX: cfg.xmax <= cfg_wdata;
        REG_YMAX: cfg.ymax <= cfg_wdata;
        REG_MODE: cfg.mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  lswc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .head     (head),
    .pop      (pop)
  );

  lswc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .visible      (visible),
    .clip_start_x (clip_start_x),
    .clip_start_y (clip_start_y),
    .clip_end_x   (clip_end_x),
    .clip_end_y   (clip_end_y)
  );

endmodule

/* src/lswc_front.sv */
// Front end: accepts segment requests, classifies them and queues them for the back end.
module lswc_front (
  input  logic            clk,
  input  logic            rst,
  input  lswc_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  lswc_pkg::coord_t start_x,
  input  lswc_pkg::coord_t start_y,
  input  lswc_pkg::coord_t end_x,
  input  lswc_pkg::coord_t end_y,
  output lswc_pkg::fq_t   head,
  input  logic            pop
);
  import lswc_pkg::*;

  seg_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic [1:0] kind;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;

  always_comb begin
    if ((cfg.xmin > cfg.xmax) || (cfg.ymin > cfg.ymax)) begin
      kind = KIND_REJECT;
    end else if (cfg.mode) begin
      kind = KIND_CS;
    end else begin
      kind = KIND_LB;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{kind: kind, ax: start_x, ay: start_y, bx: end_x, by: end_y};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign head.avail = (count != 2'd0);
  assign head.seg   = slot[rd_ptr];

endmodule

/* src/lswc_div.sv */
// Iterative divider giving q * 2^28 / p, one quotient bit a cycle, saturated beyond 1.0.
module lswc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  lswc_pkg::diff_t            num,
  input  lswc_pkg::diff_t            den,
  output logic                       done,
  output logic signed [lswc_pkg::RW-1:0] res
);
  import lswc_pkg::*;

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DW:0]     rem;
  logic [DW-1:0]   da;
  logic [UW-1:0]   mag;
  logic            neg;
  logic [DW-1:0]   na_in;
  logic [DW-1:0]   da_in;
  logic            ge;
  logic [DW:0]     rem_sub;
  logic [UW-1:0]   mag_next;

  assign na_in    = num[DW-1] ? DW'(-num) : DW'(num);
  assign da_in    = den[DW-1] ? DW'(-den) : DW'(den);
  assign ge       = (rem >= {1'b0, da});
  assign rem_sub  = ge ? (rem - {1'b0, da}) : rem;
  assign mag_next = {mag[UW-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= num[DW-1] ^ den[DW-1];
        da  <= da_in;
        // A ratio above one only has to compare as above one, so it is saturated.
        if (na_in > da_in) begin
          res  <= (num[DW-1] ^ den[DW-1]) ? -$signed({1'b0, U_ONE + UW'(1)})
                                          : $signed({1'b0, U_ONE + UW'(1)});
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          rem  <= {1'b0, na_in};
          mag  <= '0;
          cnt  <= '0;
        end
      end else if (busy) begin
        mag <= mag_next;
        rem <= {rem_sub[DW-1:0], 1'b0};
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(UW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          res  <= neg ? -$signed({1'b0, mag_next}) : $signed({1'b0, mag_next});
        end
      end
    end
  end

endmodule

/* src/lswc_back.sv */
// Back end: runs the clipping sequence on a shared divider and multiplier, holds the result.
module lswc_back (
  input  logic             clk,
  input  logic             rst,
  input  lswc_pkg::cfg_t   cfg,
  input  lswc_pkg::fq_t    head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             visible,
  output lswc_pkg::coord_t clip_start_x,
  output lswc_pkg::coord_t clip_start_y,
  output lswc_pkg::coord_t clip_end_x,
  output lswc_pkg::coord_t clip_end_y
);
  import lswc_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LB_TEST = 4'd1;
  localparam logic [3:0] S_LB_WAIT = 4'd2;
  localparam logic [3:0] S_LB_S1   = 4'd3;
  localparam logic [3:0] S_LB_S2   = 4'd4;
  localparam logic [3:0] S_LB_S3   = 4'd5;
  localparam logic [3:0] S_LB_E1   = 4'd6;
  localparam logic [3:0] S_LB_E2   = 4'd7;
  localparam logic [3:0] S_LB_E3   = 4'd8;
  localparam logic [3:0] S_CS_TEST = 4'd9;
  localparam logic [3:0] S_CS_WAIT = 4'd10;
  localparam logic [3:0] S_CS_MOVE = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  logic [3:0]    state;
  coord_t        ax, ay, bx, by, ox, oy;
  diff_t         dx, dy;
  logic [1:0]    k, k1, k2;
  logic [UW-1:0] u1, u2;
  logic [2:0]    moves;
  logic          vis_r;
  logic          cs_first;
  logic          cs_yedge;
  coord_t        cs_edge;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_full;

  diff_t         lb_p, lb_q;
  logic [3:0]    c1, c2, oc;
  logic          n_yedge;
  coord_t        n_edge;
  coord_t        s0, s1;
  diff_t         cs_den, cs_num;
  coord_t        o0, o1;
  coord_t        other;
  logic [UW-1:0] t_clamp;
  logic [UW-1:0] mul_u;
  diff_t         mul_d;
  logic          div_start;
  diff_t         div_num, div_den;
  logic          div_done;
  logic signed [RW-1:0] div_res;
  logic signed [RW-1:0] u1s, u2s;
  logic          load_out;

  function automatic coord_t rnd(input logic signed [PW-1:0] t, input coord_t base);
    logic [PW-1:0] m;
    logic [PW-1:0] s;
    logic [CW-1:0] mm;
    m  = t[PW-1] ? PW'(-t) : PW'(t);
    s  = (m + (PW'(1) << (U_BITS - 1))) >> U_BITS;
    mm = s[CW-1:0];
    return t[PW-1] ? coord_t'(base - mm) : coord_t'(base + mm);
  endfunction

  function automatic logic [3:0] outcode(input coord_t x, input coord_t y, input cfg_t c);
    logic [3:0] r;
    r = 4'b0000;
    if (x < c.xmin) begin
      r = r | OC_LEFT;
    end else if (x > c.xmax) begin
      r = r | OC_RIGHT;
    end
    if (y < c.ymin) begin
      r = r | OC_BOTTOM;
    end else if (y > c.ymax) begin
      r = r | OC_TOP;
    end
    return r;
  endfunction

  function automatic coord_t edge_of(input logic [1:0] idx, input cfg_t c);
    coord_t e;
    case (idx)
      2'd0:    e = c.xmin;
      2'd1:    e = c.xmax;
      2'd2:    e = c.ymin;
      default: e = c.ymax;
    endcase
    return e;
  endfunction

  // Liang-Barsky edge test k: p is the direction term, q the distance to the edge.
  always_comb begin
    case (k)
      2'd0: begin
        lb_p = -dx;
        lb_q = diff_t'(ax) - diff_t'(cfg.xmin);
      end
      2'd1: begin
        lb_p = dx;
        lb_q = diff_t'(cfg.xmax) - diff_t'(ax);
      end
      2'd2: begin
        lb_p = -dy;
        lb_q = diff_t'(ay) - diff_t'(cfg.ymin);
      end
      default: begin
        lb_p = dy;
        lb_q = diff_t'(cfg.ymax) - diff_t'(ay);
      end
    endcase
  end

  // Cohen-Sutherland: the endpoint with the larger outcode moves onto one edge.
  always_comb begin
    c1 = outcode(ax, ay, cfg);
    c2 = outcode(bx, by, cfg);
    oc = (c2 > c1) ? c2 : c1;
    if ((oc & OC_TOP) != 4'b0000) begin
      n_yedge = 1'b1;
      n_edge  = cfg.ymax;
    end else if ((oc & OC_BOTTOM) != 4'b0000) begin
      n_yedge = 1'b1;
      n_edge  = cfg.ymin;
    end else if ((oc & OC_RIGHT) != 4'b0000) begin
      n_yedge = 1'b0;
      n_edge  = cfg.xmax;
    end else begin
      n_yedge = 1'b0;
      n_edge  = cfg.xmin;
    end
    s0     = n_yedge ? ay : ax;
    s1     = n_yedge ? by : bx;
    cs_den = diff_t'(s1) - diff_t'(s0);
    cs_num = diff_t'(n_edge) - diff_t'(s0);
    o0     = cs_yedge ? ax : ay;
    o1     = cs_yedge ? bx : by;
    other  = rnd(prod, o0);
    if (div_res[RW-1]) begin
      t_clamp = '0;
    end else if (div_res > $signed({1'b0, U_ONE})) begin
      t_clamp = U_ONE;
    end else begin
      t_clamp = div_res[UW-1:0];
    end
  end

  always_comb begin
    case (state)
      S_LB_S2: begin
        mul_u = u1;
        mul_d = dy;
      end
      S_LB_E1: begin
        mul_u = u2;
        mul_d = dx;
      end
      S_LB_E2: begin
        mul_u = u2;
        mul_d = dy;
      end
      S_CS_WAIT: begin
        mul_u = t_clamp;
        mul_d = diff_t'(o1) - diff_t'(o0);
      end
      default: begin
        mul_u = u1;
        mul_d = dx;
      end
    endcase
  end

  assign prod_full = $signed({1'b0, mul_u}) * mul_d;

  assign div_start = ((state == S_LB_TEST) && (lb_p != '0)) ||
                     ((state == S_CS_TEST) && ((c1 | c2) != 4'b0000) &&
                      ((c1 & c2) == 4'b0000) && (moves < 3'(CS_MAX_MOVES)) &&
                      (cs_den != '0));
  assign div_num   = (state == S_CS_TEST) ? cs_num : lb_q;
  assign div_den   = (state == S_CS_TEST) ? cs_den : lb_p;

  lswc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .res   (div_res)
  );

  assign u1s      = $signed({1'b0, u1});
  assign u2s      = $signed({1'b0, u2});
  assign pop      = (state == S_IDLE) && head.avail;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    prod <= prod_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (head.avail) begin
            ax    <= head.seg.ax;
            ay    <= head.seg.ay;
            bx    <= head.seg.bx;
            by    <= head.seg.by;
            ox    <= head.seg.ax;
            oy    <= head.seg.ay;
            dx    <= diff_t'(head.seg.bx) - diff_t'(head.seg.ax);
            dy    <= diff_t'(head.seg.by) - diff_t'(head.seg.ay);
            k     <= 2'd0;
            k1    <= 2'd0;
            k2    <= 2'd0;
            u1    <= '0;
            u2    <= U_ONE;
            moves <= '0;
            case (head.seg.kind)
              KIND_LB: state <= S_LB_TEST;
              KIND_CS: state <= S_CS_TEST;
              default: begin
                vis_r <= 1'b0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_LB_TEST: begin
          if (lb_p != '0) begin
            state <= S_LB_WAIT;
          end else if (lb_q[DW-1]) begin
            vis_r <= 1'b0;
            state <= S_DONE;
          end else begin
            k     <= k + 2'd1;
            state <= (k == 2'd3) ? S_LB_S1 : S_LB_TEST;
          end
        end
        S_LB_WAIT: begin
          if (div_done) begin
            k     <= k + 2'd1;
            state <= (k == 2'd3) ? S_LB_S1 : S_LB_TEST;
            if (lb_p[DW-1]) begin
              if (div_res > u2s) begin
                vis_r <= 1'b0;
                state <= S_DONE;
              end else if (div_res > u1s) begin
                u1 <= div_res[UW-1:0];
                k1 <= k;
              end
            end else begin
              if (div_res < u1s) begin
                vis_r <= 1'b0;
                state <= S_DONE;
              end else if (div_res < u2s) begin
                u2 <= div_res[UW-1:0];
                k2 <= k;
              end
            end
          end
        end
        S_LB_S1: begin
          state <= (u1 != '0) ? S_LB_S2 : S_LB_E1;
        end
        S_LB_S2: begin
          ax    <= k1[1] ? rnd(prod, ox) : edge_of(k1, cfg);
          state <= S_LB_S3;
        end
        S_LB_S3: begin
          ay    <= k1[1] ? edge_of(k1, cfg) : rnd(prod, oy);
          state <= S_LB_E1;
        end
        S_LB_E1: begin
          if (u2 != U_ONE) begin
            state <= S_LB_E2;
          end else begin
            vis_r <= 1'b1;
            state <= S_DONE;
          end
        end
        S_LB_E2: begin
          bx    <= k2[1] ? rnd(prod, ox) : edge_of(k2, cfg);
          state <= S_LB_E3;
        end
        S_LB_E3: begin
          by    <= k2[1] ? edge_of(k2, cfg) : rnd(prod, oy);
          vis_r <= 1'b1;
          state <= S_DONE;
        end
        S_CS_TEST: begin
          if ((c1 | c2) == 4'b0000) begin
            vis_r <= 1'b1;
            state <= S_DONE;
          end else if (div_start) begin
            moves    <= moves + 3'd1;
            cs_first <= (oc == c1);
            cs_yedge <= n_yedge;
            cs_edge  <= n_edge;
            state    <= S_CS_WAIT;
          end else begin
            vis_r <= 1'b0;
            state <= S_DONE;
          end
        end
        S_CS_WAIT: begin
          if (div_done) begin
            state <= S_CS_MOVE;
          end
        end
        S_CS_MOVE: begin
          if (cs_first) begin
            ax <= cs_yedge ? other : cs_edge;
            ay <= cs_yedge ? cs_edge : other;
          end else begin
            bx <= cs_yedge ? other : cs_edge;
            by <= cs_yedge ? cs_edge : other;
          end
          state <= S_CS_TEST;
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: the sequencer moves on while a result waits to be taken.
  always_ff @(posedge clk) begin
    if (load_out) begin
      visible      <= vis_r;
      clip_start_x <= vis_r ? ax : '0;
      clip_start_y <= vis_r ? ay : '0;
      clip_end_x   <= vis_r ? bx : '0;
      clip_end_y   <= vis_r ? by : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* src/lswc_check.sv */
// Port checker for the line segment window clipper, bound to the top level.
module lswc_check (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic             visible,
  input lswc_pkg::coord_t clip_start_x,
  input lswc_pkg::coord_t clip_start_y,
  input lswc_pkg::coord_t clip_end_x,
  input lswc_pkg::coord_t clip_end_y
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(visible) && $stable(clip_start_x) &&
      $stable(clip_start_y) && $stable(clip_end_x) && $stable(clip_end_y))
    else $error("stalled result changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> clip_start_x == '0 && clip_start_y == '0 &&
      clip_end_x == '0 && clip_end_y == '0)
    else $error("rejected segment has non-zero endpoints");

endmodule

bind line_segment_window_clipper lswc_check u_lswc_check (.*);
